/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the codec RTL.
// Expects clk_i and rst_ni in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset
`define ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/spk_pkg.sv */
// Package for the encrypted ID codec: constants, state enum, alphabet helpers.
// No dependencies.
package spk_pkg;

  localparam int unsigned ROUNDS     = 32;
  localparam int unsigned STR_LEN    = 27;
  localparam int unsigned CHECK_BITS = 48;
  localparam int unsigned LIMBS      = 8;    // 16-bit limbs of the 128-bit block
  localparam int unsigned CNT_W      = $clog2(ROUNDS);
  localparam int unsigned POS_W      = $clog2(STR_LEN);
  localparam int unsigned LIMB_W     = $clog2(LIMBS);

  localparam logic [63:0] GEN_OFFSET = 64'd1111111111111111111;
  localparam logic [63:0] GEN_MULT   = 64'h3243f6a8885a308d;

  localparam logic [8*30-1:0] ALPHABET = "0123456789bcdfghjkmnpqrstvwxyz";

  // Configuration register indexes
  localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [1:0] CFG_SEED     = 2'd2;

  typedef enum logic [3:0] {
    ST_KLOAD,
    ST_SCHED,
    ST_IDLE,
    ST_GEN0,
    ST_GEN1,
    ST_GEN2,
    ST_ENC,
    ST_DIV,
    ST_EMIT,
    ST_DEC,
    ST_VERDICT
  } state_e;

  typedef enum logic {
    DIR_FWD,
    DIR_INV
  } round_dir_e;

  typedef struct packed {
    logic       ok;
    logic [4:0] val;
  } digit_t;

  // Character to base-30 digit
  function automatic digit_t digit_of(input logic [7:0] c);
    digit_t res;
    res = '0;
    for (int i = 0; i < 30; i++) begin
      if (c == ALPHABET[(29 - i) * 8 +: 8]) begin
        res.ok  = 1'b1;
        res.val = 5'(i);
      end
    end
    return res;
  endfunction

  // Base-30 digit to character
  function automatic logic [7:0] char_of(input logic [4:0] d);
    logic [7:0] c;
    c = '0;
    for (int i = 0; i < 30; i++) begin
      if (d == 5'(i)) c = ALPHABET[(29 - i) * 8 +: 8];
    end
    return c;
  endfunction

endpackage

/* hw/rtl/spk_ifs.sv */
// Request and result channel interfaces of the codec.
// Depends on nothing but plain logic types.
interface spk_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] id;
  logic [7:0]  char_in;
  modport source (output valid, mode, id, char_in, input ready);
  modport sink   (input valid, mode, id, char_in, output ready);
endinterface

interface spk_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  char_out;
  logic        last;
  logic [63:0] id_out;
  logic        ok;
  modport source (output valid, kind, char_out, last, id_out, ok, input ready);
  modport sink   (input valid, kind, char_out, last, id_out, ok, output ready);
endinterface

/* hw/rtl/spk_round.sv */
// Shared Speck128 round unit, forward and inverse; also runs the key schedule.
// Depends on spk_pkg.
module spk_round (
  input  spk_pkg::round_dir_e dir_i,
  input  logic [63:0]         x_i,
  input  logic [63:0]         y_i,
  input  logic [63:0]         k_i,
  output logic [63:0]         x_o,
  output logic [63:0]         y_o
);

  logic [63:0] fx, fy, iy, ix;

  // forward: x = (ror8(x) + y) ^ k; y = rol3(y) ^ x
  assign fx = ({x_i[7:0], x_i[63:8]} + y_i) ^ k_i;
  assign fy = {y_i[60:0], y_i[63:61]} ^ fx;

  // inverse: y = ror3(y ^ x); x = rol8((x ^ k) - y)
  logic [63:0] yx, xd;
  assign yx = y_i ^ x_i;
  assign iy = {yx[2:0], yx[63:3]};
  assign xd = (x_i ^ k_i) - iy;
  assign ix = {xd[55:0], xd[63:56]};

  always_comb begin
    if (dir_i == spk_pkg::DIR_INV) begin
      x_o = ix;
      y_o = iy;
    end else begin
      x_o = fx;
      y_o = fy;
    end
  end

endmodule

/* hw/rtl/spk_div30.sv */
// One long-division step by 30 on a 16-bit limb with incoming remainder.
// Depends on nothing; reciprocal multiply with a single correction.
module spk_div30 (
  input  logic [20:0] cur_i,   // {rem, limb}, below 30 * 2^16
  output logic [15:0] quo_o,
  output logic [4:0]  rem_o
);

  localparam logic [19:0] RECIP = 20'd559240;  // floor(2^24 / 30)

  logic [40:0] prod;
  logic [15:0] q0;
  logic [21:0] r0;

  // estimate is exact or one low
  assign prod = 41'(cur_i) * 41'(RECIP);
  assign q0   = prod[39:24];
  assign r0   = 22'(cur_i) - (22'(q0) << 5) + (22'(q0) << 1);

  always_comb begin
    if (r0 >= 22'd30) begin
      quo_o = q0 + 16'd1;
      rem_o = 5'(r0 - 22'd30);
    end else begin
      quo_o = q0;
      rem_o = r0[4:0];
    end
  end

endmodule

/* hw/rtl/speck_encrypted_id_codec.sv */
// Channel     Dir  Payload                               Accepted when
// req_i       in   mode, id[63:0], char_in[7:0]          valid && ready
// res_o       out  kind, char_out[7:0], last, id_out, ok valid && ready
// cfg         in   cfg_we_i, cfg_idx_i[1:0], cfg_data_i  cfg_we_i high
// Encrypt: accept, the LCG multiply (GEN0 to GEN2), 32 rounds, 216 divide steps (27 digits x
//   8 limbs through one divide-by-30 unit) and 27 result characters.
// Decrypt: one character per request; the 27th adds 32 inverse rounds (skipped when
//   the string is bad) and the verdict.
// After reset or a key write the key schedule runs with ready held low.
// A stalled result holds the block; ready is high only while idle.
`include "assert_macros.svh"

module speck_encrypted_id_codec (
  input  logic            clk_i,
  input  logic            rst_ni,
  spk_req_if.sink         req_i,
  spk_res_if.source       res_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [63:0]     cfg_data_i
);

  localparam int unsigned CW = spk_pkg::CNT_W;
  localparam int unsigned PW = spk_pkg::POS_W;
  localparam int unsigned LW = spk_pkg::LIMB_W;

  spk_pkg::state_e state_q, state_d;

  // control registers
  logic [63:0]  key_lo_q, key_hi_q, gen_q;
  logic [127:0] acc_q;
  logic [PW-1:0] pos_q, dcnt_q, eidx_q;
  logic          bad_q;
  logic [CW-1:0] cnt_q;
  logic [LW-1:0] limb_q;

  // payload registers
  logic [63:0] x_q, y_q, t_q;
  logic [63:0] rk_q [spk_pkg::ROUNDS];
  logic [4:0]  dig_q [spk_pkg::STR_LEN];
  logic [4:0]  rem_q;
  logic        vbad_q;

  logic req_acc, res_acc, key_wr;
  assign req_acc = req_i.valid && req_i.ready;
  assign res_acc = res_o.valid && res_o.ready;
  assign key_wr  = cfg_we_i && (cfg_idx_i == spk_pkg::CFG_KEY_LOW ||
                                cfg_idx_i == spk_pkg::CFG_KEY_HIGH);

  // decrypt accumulate: acc * 30 + digit, overflow past 128 bits is bad
  spk_pkg::digit_t dg;
  logic [132:0] acc_mul;
  logic [127:0] acc_nx;
  logic         bad_nx;
  logic [PW-1:0] pos_inc;
  logic          str_end;

  assign dg      = spk_pkg::digit_of(req_i.char_in);
  assign acc_mul = ({5'b0, acc_q} << 5) - ({5'b0, acc_q} << 1) + 133'(dg.val);
  assign pos_inc = pos_q + 1'b1;
  assign str_end = (pos_inc == PW'(spk_pkg::STR_LEN));

  always_comb begin
    acc_nx = acc_q;
    bad_nx = bad_q;
    if (!bad_q) begin
      if (!dg.ok || acc_mul[132:128] != 5'd0) bad_nx = 1'b1;
      else acc_nx = acc_mul[127:0];
    end
  end

  // LCG step with one 32x32 multiplier shared by states GEN0, GEN1 and GEN2
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod, gen_nx;
  assign mul_a  = (state_q == spk_pkg::ST_GEN2) ? gen_q[63:32] : gen_q[31:0];
  assign mul_b  = (state_q == spk_pkg::ST_GEN1) ? spk_pkg::GEN_MULT[63:32]
                                                : spk_pkg::GEN_MULT[31:0];
  assign prod   = 64'(mul_a) * 64'(mul_b);
  assign gen_nx = t_q + {prod[31:0], 32'b0} + 64'd1;

  // round unit: schedule, encrypt and decrypt
  spk_pkg::round_dir_e dir;
  logic [63:0] rkey, rx, ry;
  assign dir  = (state_q == spk_pkg::ST_DEC) ? spk_pkg::DIR_INV : spk_pkg::DIR_FWD;
  assign rkey = (state_q == spk_pkg::ST_SCHED) ? 64'(cnt_q) : rk_q[cnt_q];

  spk_round u_round (
    .dir_i (dir),
    .x_i   (x_q),
    .y_i   (y_q),
    .k_i   (rkey),
    .x_o   (rx),
    .y_o   (ry)
  );

  // divide step on one limb, most significant first
  logic [127:0] blk, blk_nx;
  logic [15:0]  quo;
  logic [4:0]   rem;
  assign blk = {x_q, y_q};

  spk_div30 u_div (
    .cur_i ({rem_q, blk[limb_q * 16 +: 16]}),
    .quo_o (quo),
    .rem_o (rem)
  );

  always_comb begin
    blk_nx = blk;
    blk_nx[limb_q * 16 +: 16] = quo;
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= spk_pkg::ST_KLOAD;
    else         state_q <= state_d;
  end

  // next state and channel outputs
  always_comb begin
    state_d        = state_q;
    req_i.ready    = 1'b0;
    res_o.valid    = 1'b0;
    res_o.kind     = 1'b0;
    res_o.char_out = '0;
    res_o.last     = 1'b0;
    res_o.id_out   = '0;
    res_o.ok       = 1'b0;
    unique case (state_q)
      spk_pkg::ST_KLOAD: state_d = spk_pkg::ST_SCHED;
      spk_pkg::ST_SCHED: begin
        if (cnt_q == CW'(spk_pkg::ROUNDS - 2)) state_d = spk_pkg::ST_IDLE;
      end
      spk_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_acc) begin
          if (!req_i.mode)  state_d = spk_pkg::ST_GEN0;
          else if (str_end) state_d = bad_nx ? spk_pkg::ST_VERDICT : spk_pkg::ST_DEC;
        end
      end
      spk_pkg::ST_GEN0: state_d = spk_pkg::ST_GEN1;
      spk_pkg::ST_GEN1: state_d = spk_pkg::ST_GEN2;
      spk_pkg::ST_GEN2: state_d = spk_pkg::ST_ENC;
      spk_pkg::ST_ENC: begin
        if (cnt_q == CW'(spk_pkg::ROUNDS - 1)) state_d = spk_pkg::ST_DIV;
      end
      spk_pkg::ST_DIV: begin
        if (limb_q == '0 && dcnt_q == PW'(spk_pkg::STR_LEN - 1))
          state_d = spk_pkg::ST_EMIT;
      end
      spk_pkg::ST_EMIT: begin
        res_o.valid    = 1'b1;
        res_o.char_out = spk_pkg::char_of(dig_q[eidx_q]);
        res_o.last     = (eidx_q == '0);
        if (res_acc && eidx_q == '0) state_d = spk_pkg::ST_IDLE;
      end
      spk_pkg::ST_DEC: begin
        if (cnt_q == '0) state_d = spk_pkg::ST_VERDICT;
      end
      spk_pkg::ST_VERDICT: begin
        res_o.valid  = 1'b1;
        res_o.kind   = 1'b1;
        res_o.last   = 1'b1;
        res_o.id_out = vbad_q ? '0 : x_q;
        res_o.ok     = !vbad_q && (y_q[63:64-spk_pkg::CHECK_BITS] == '0);
        if (res_acc) state_d = spk_pkg::ST_IDLE;
      end
      default: state_d = spk_pkg::ST_IDLE;
    endcase
    if (key_wr) state_d = spk_pkg::ST_KLOAD;
  end

  // control datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q <= '0;
      key_hi_q <= '0;
      gen_q    <= spk_pkg::GEN_OFFSET;
      acc_q    <= '0;
      pos_q    <= '0;
      bad_q    <= 1'b0;
      cnt_q    <= '0;
      limb_q   <= '0;
      dcnt_q   <= '0;
      eidx_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          spk_pkg::CFG_KEY_LOW:  key_lo_q <= cfg_data_i;
          spk_pkg::CFG_KEY_HIGH: key_hi_q <= cfg_data_i;
          spk_pkg::CFG_SEED:     gen_q    <= cfg_data_i + spk_pkg::GEN_OFFSET;
          default: ;
        endcase
      end
      case (state_q)
        spk_pkg::ST_KLOAD: cnt_q <= '0;
        spk_pkg::ST_SCHED: cnt_q <= cnt_q + 1'b1;
        spk_pkg::ST_IDLE: begin
          if (req_acc) begin
            if (!req_i.mode) begin
              cnt_q <= '0;
            end else if (str_end) begin
              acc_q <= '0;
              pos_q <= '0;
              bad_q <= 1'b0;
              cnt_q <= CW'(spk_pkg::ROUNDS - 1);
            end else begin
              acc_q <= acc_nx;
              bad_q <= bad_nx;
              pos_q <= pos_inc;
            end
          end
        end
        spk_pkg::ST_GEN2: gen_q <= gen_nx;
        spk_pkg::ST_ENC: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(spk_pkg::ROUNDS - 1)) begin
            limb_q <= LW'(spk_pkg::LIMBS - 1);
            dcnt_q <= '0;
          end
        end
        spk_pkg::ST_DIV: begin
          limb_q <= limb_q - 1'b1;
          if (limb_q == '0) begin
            dcnt_q <= dcnt_q + 1'b1;
            if (dcnt_q == PW'(spk_pkg::STR_LEN - 1)) eidx_q <= PW'(spk_pkg::STR_LEN - 1);
          end
        end
        spk_pkg::ST_EMIT: begin
          if (res_acc) eidx_q <= eidx_q - 1'b1;
        end
        spk_pkg::ST_DEC: cnt_q <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

  // payload datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      spk_pkg::ST_KLOAD: begin
        x_q      <= key_hi_q;
        y_q      <= key_lo_q;
        rk_q[0]  <= key_lo_q;
      end
      spk_pkg::ST_SCHED: begin
        x_q <= rx;
        y_q <= ry;
        rk_q[CW'(cnt_q + 1'b1)] <= ry;
      end
      spk_pkg::ST_IDLE: begin
        if (req_acc) begin
          if (!req_i.mode) begin
            x_q <= req_i.id;
          end else if (str_end) begin
            x_q    <= acc_nx[127:64];
            y_q    <= acc_nx[63:0];
            vbad_q <= bad_nx;
          end
        end
      end
      spk_pkg::ST_GEN0: t_q <= prod;
      spk_pkg::ST_GEN1: t_q <= t_q + {prod[31:0], 32'b0};
      spk_pkg::ST_GEN2: y_q <= 64'(gen_nx >> spk_pkg::CHECK_BITS);
      spk_pkg::ST_ENC: begin
        x_q   <= rx;
        y_q   <= ry;
        rem_q <= '0;
      end
      spk_pkg::ST_DIV: begin
        {x_q, y_q} <= blk_nx;
        if (limb_q == '0) begin
          dig_q[dcnt_q] <= rem;
          rem_q         <= '0;
        end else begin
          rem_q <= rem;
        end
      end
      spk_pkg::ST_DEC: begin
        x_q <= rx;
        y_q <= ry;
      end
      default: ;
    endcase
  end

  // checks
  `ASSERT_NOW(a_ready_no_result, !(req_i.ready && res_o.valid), "ready while result pending")
  `ASSERT_NOW(a_pos_range, pos_q < PW'(spk_pkg::STR_LEN), "position beyond string length")
  `ASSERT_NOW(a_verdict_cleared, !(res_o.valid && res_o.kind) || (pos_q == '0 && acc_q == '0),
              "decrypt state not cleared at verdict")
  `ASSERT_NEXT(a_emit_step, state_q == spk_pkg::ST_EMIT && res_acc && eidx_q != '0 && !key_wr,
               state_q == spk_pkg::ST_EMIT && eidx_q == PW'($past(eidx_q) - 1'b1),
               "digit index did not step")

endmodule

/* bench/tb_speck_encrypted_id_codec_ifs.sv */
`timescale 1ns / 1ps
// Bench side of the request and result channels.
// The interfaces themselves come from the RTL folder (spk_req_if, spk_res_if).

/* bench/tb_speck_encrypted_id_codec.sv */
`timescale 1ns / 1ps
// Self-checking bench for the encrypted ID codec: random and directed requests,
// an internal cipher/base-30 predictor and an in-order result scoreboard.
// Depends on spk_pkg, the channel interfaces and speck_encrypted_id_codec.

typedef struct packed {
  logic        kind;
  logic [7:0]  char_out;
  logic        last;
  logic [63:0] id_out;
  logic        ok;
} codec_res_t;

class codec_scoreboard;
  logic [63:0] sched_keys [32];
  logic [63:0] key_lo, key_hi, lcg;
  logic [127:0] acc;
  int unsigned  pos;
  bit           bad;
  codec_res_t   pending [$];
  int unsigned  errors;

  function new();
    key_lo = '0;
    key_hi = '0;
    lcg    = spk_pkg::GEN_OFFSET;
    acc    = '0;
    pos    = 0;
    bad    = 0;
    errors = 0;
    expand_keys();
  endfunction

  function void expand_keys();
    logic [63:0] l, k;
    l = key_hi;
    k = key_lo;
    sched_keys[0] = k;
    for (int i = 0; i < 31; i++) begin
      l = ({l[7:0], l[63:8]} + k) ^ 64'(i);
      k = {k[60:0], k[63:61]} ^ l;
      sched_keys[i+1] = k;
    end
  endfunction

  function void write_reg(logic [1:0] idx, logic [63:0] v);
    case (idx)
      spk_pkg::CFG_KEY_LOW: begin
        key_lo = v;
        expand_keys();
      end
      spk_pkg::CFG_KEY_HIGH: begin
        key_hi = v;
        expand_keys();
      end
      spk_pkg::CFG_SEED: lcg = v + spk_pkg::GEN_OFFSET;
      default: ;
    endcase
  endfunction

  function int digit_val(logic [7:0] c);
    string abc;
    abc = "0123456789bcdfghjkmnpqrstvwxyz";
    for (int d = 0; d < 30; d++)
      if (abc[d] == c) return d;
    return -1;
  endfunction

  // Note an accepted request and queue the results it causes
  function void note_request(logic mode, logic [63:0] id, logic [7:0] ch);
    logic [63:0] x, y;
    logic [127:0] v;
    logic [132:0] wide;
    codec_res_t r, digs [27];
    string abc;
    int d;
    abc = "0123456789bcdfghjkmnpqrstvwxyz";
    if (mode == 1'b0) begin
      lcg = lcg * spk_pkg::GEN_MULT + 64'd1;
      x = id;
      y = lcg >> 48;
      for (int k = 0; k < 32; k++) begin
        x = {x[7:0], x[63:8]};
        x = x + y;
        x = x ^ sched_keys[k];
        y = {y[60:0], y[63:61]};
        y = y ^ x;
      end
      v = {x, y};
      for (int k = 26; k >= 0; k--) begin
        r = '0;
        r.char_out = abc[v % 30];
        r.last = (k == 26);
        digs[k] = r;
        v = v / 30;
      end
      for (int k = 0; k < 27; k++) pending.push_back(digs[k]);
      return;
    end
    if (!bad) begin
      d = digit_val(ch);
      if (d < 0) bad = 1;
      else begin
        // full-width product so a carry past 128 bits is seen
        wide = {5'b0, acc} * 133'd30 + 133'(d);
        if (wide[132:128] != 5'd0) bad = 1;
        else acc = wide[127:0];
      end
    end
    pos = (pos + 1) & 31;
    if (pos < 27) return;
    r = '0;
    r.kind = 1'b1;
    r.last = 1'b1;
    if (!bad) begin
      x = acc[127:64];
      y = acc[63:0];
      for (int k = 31; k >= 0; k--) begin
        y = y ^ x;
        y = {y[2:0], y[63:3]};
        x = x ^ sched_keys[k];
        x = x - y;
        x = {x[55:0], x[63:56]};
      end
      r.id_out = x;
      r.ok = (y[63:16] == 48'd0);
    end
    pending.push_back(r);
    acc = '0;
    pos = 0;
    bad = 0;
  endfunction

  // Compare one accepted result against the oldest expectation
  function void check_result(codec_res_t got);
    codec_res_t exp_r;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %p", got);
      return;
    end
    exp_r = pending.pop_front();
    if (got !== exp_r) begin
      errors++;
      if (errors <= 10) $display("mismatch: expected %p got %p", exp_r, got);
    end
  endfunction
endclass

module tb_speck_encrypted_id_codec;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [63:0] cfg_data_i;
  int          src_idle_pct, sink_stall_pct;
  longint      cycles;
  codec_scoreboard sb;

  spk_req_if req_ch ();
  spk_res_if res_ch ();

  speck_encrypted_id_codec uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_ch.sink),
    .res_o     (res_ch.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Timeout watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 3000000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Result sink with random stalls
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_ch.valid && res_ch.ready)
        sb.check_result({res_ch.kind, res_ch.char_out, res_ch.last,
                         res_ch.id_out, res_ch.ok});
      res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // valid stays high after an accept; the next request drives it anew, or drain() lowers it
  task automatic send_request(logic mode, logic [63:0] id, logic [7:0] ch);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid   <= 1'b1;
    req_ch.mode    <= mode;
    req_ch.id      <= id;
    req_ch.char_in <= ch;
    do @(posedge clk_i); while (!req_ch.ready);
    sb.note_request(mode, id, ch);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [63:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.write_reg(idx, v);
    cfg_we_i <= 1'b0;
    // key writes rerun the schedule; ready gates the next request
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] alpha_char(int d);
    string abc;
    abc = "0123456789bcdfghjkmnpqrstvwxyz";
    return abc[d];
  endfunction

  // One decrypt string: valid, or with one character replaced by a random byte
  task automatic send_string(logic [127:0] val, bit corrupt);
    logic [7:0] chs [27];
    int bad_at;
    for (int k = 26; k >= 0; k--) begin
      chs[k] = alpha_char(int'(val % 30));
      val = val / 30;
    end
    bad_at = corrupt ? $urandom_range(26) : -1;
    for (int k = 0; k < 27; k++) begin
      if (k == bad_at) send_request(1'b1, {$urandom, $urandom}, 8'($urandom));
      else send_request(1'b1, {$urandom, $urandom}, chs[k]);
    end
  endtask

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Cipher value of the most recent encrypt, rebuilt from its queued digits
  function automatic logic [127:0] predict_block();
    logic [127:0] v;
    codec_res_t r;
    int n;
    v = '0;
    n = sb.pending.size();
    for (int k = n - 27; k < n; k++) begin
      r = sb.pending[k];
      v = v * 30 + 128'(sb.digit_val(r.char_out));
    end
    return v;
  endfunction

  task automatic round_trip(logic [63:0] id);
    logic [127:0] blk;
    send_request(1'b0, id, 8'($urandom));
    blk = predict_block();
    send_string(blk, 1'b0);
  endtask

  task automatic random_phase(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 40) round_trip({$urandom, $urandom});
      else if (sel < 70) send_request(1'b0, {$urandom, $urandom}, 8'($urandom));
      else if (sel < 80) send_string(rand128(), 1'b1);
      else if (sel < 90) send_string(rand128(), 1'b0);
      else send_request(1'b1, {$urandom, $urandom}, 8'($urandom));
    end
  endtask

  initial begin
    sb = new();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    req_ch.valid   = 1'b0;
    req_ch.mode    = 1'b0;
    req_ch.id      = '0;
    req_ch.char_in = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = spk_pkg::CFG_KEY_LOW;
    cfg_data_i     = '0;
    rst_ni         = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset key, id extremes, overflow, bad char, interleave
    send_request(1'b0, 64'd0, 8'h00);
    send_request(1'b0, {64{1'b1}}, 8'hff);
    round_trip(64'h0123_4567_89ab_cdef);
    for (int k = 0; k < 27; k++) send_request(1'b1, '0, "z");
    for (int k = 0; k < 27; k++) send_request(1'b1, '0, "0");
    for (int k = 0; k < 27; k++) send_request(1'b1, '0, (k == 5) ? 8'hff : "a");
    for (int k = 0; k < 10; k++) send_request(1'b1, '0, "7");
    send_request(1'b0, 64'h8000_0000_0000_0001, 8'h00);
    for (int k = 10; k < 27; k++) send_request(1'b1, '0, "7");
    drain();

    // Register extremes and random keys across idling phases
    write_cfg(spk_pkg::CFG_KEY_LOW, {64{1'b1}});
    write_cfg(spk_pkg::CFG_KEY_HIGH, {64{1'b1}});
    write_cfg(spk_pkg::CFG_SEED, {64{1'b1}});
    random_phase(4);
    drain();
    write_cfg(spk_pkg::CFG_KEY_LOW, '0);
    write_cfg(spk_pkg::CFG_KEY_HIGH, {$urandom, $urandom});
    write_cfg(spk_pkg::CFG_SEED, '0);
    src_idle_pct = 62;
    random_phase(4);
    drain();
    write_cfg(spk_pkg::CFG_KEY_LOW, {$urandom, $urandom});
    write_cfg(spk_pkg::CFG_SEED, {$urandom, $urandom});
    src_idle_pct   = 0;
    sink_stall_pct = 62;
    random_phase(4);
    drain();
    write_cfg(spk_pkg::CFG_KEY_HIGH, '0);
    src_idle_pct = 36;
    sink_stall_pct = 36;
    random_phase(4);
    drain();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    random_phase(4);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
